// ===== hw/rtl/atpt_pkg.sv =====
// atpt_pkg: shared types and constants of the averaged two-point temperature block.
// Used by atpt_ctrl, atpt_dp and the top level; depends on nothing.
package atpt_pkg;

    // Field and register widths
    localparam int CODE_W  = 16;
    localparam int COUNT_W = 8;
    localparam int SUM_W   = 24;
    localparam int TEMP_W  = 16;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = 2;

    // Shared divider: 29-bit dividend covers 65535 * 8000, 16-bit divisor
    localparam int QUO_W     = 29;
    localparam int DIV_STEPS = QUO_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Calibration line: 80 degrees span in hundredths, 30 degrees offset
    localparam int SCALE    = 8000;
    localparam int OFFSET   = 3000;
    localparam int TEMP_MAX = 32767;
    localparam int TEMP_MIN = -32768;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_CAL_LOW      = 2'd0;
    localparam logic [IDX_W-1:0] REG_CAL_HIGH     = 2'd1;
    localparam logic [IDX_W-1:0] REG_SAMPLE_COUNT = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_SAT    = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_CAL_EQ = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;     // take one sample into the batch
        logic step;       // one divider iteration
        logic mul;        // register (mean - cal_low) * SCALE
        logic load_div2;  // load divider with product and calibration span
        logic finish;     // restore sign, offset, saturate into the output register
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic batch_close;  // the sample now offered closes the batch
    } dp_status_t;

endpackage

// ===== hw/rtl/atpt_dp.sv =====
// atpt_dp: datapath with config registers, batch accumulator, shared restoring
// divider, calibration multiplier and output register. Depends on atpt_pkg.
module atpt_dp #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [atpt_pkg::IDX_W-1:0]           cfg_index,
    input  logic [atpt_pkg::CODE_W-1:0]          cfg_data,
    input  logic [atpt_pkg::CODE_W-1:0]          sample,
    input  atpt_pkg::dp_cmd_t                    cmd,
    output atpt_pkg::dp_status_t                 stat,
    output logic signed [atpt_pkg::TEMP_W-1:0]   temperature_centi,
    output logic [atpt_pkg::STAT_W-1:0]          status
);

    localparam int CODE_W = atpt_pkg::CODE_W;
    localparam int SUM_W  = atpt_pkg::SUM_W;
    localparam int QUO_W  = atpt_pkg::QUO_W;

    logic [CODE_W-1:0]              cal_low_reg, cal_high_reg;
    logic [atpt_pkg::COUNT_W-1:0]   count_reg;
    logic [SUM_W-1:0]               sum_reg;
    logic [atpt_pkg::COUNT_W-1:0]   taken_reg;
    logic [CODE_W-1:0]              rem_reg, div_reg;
    logic [QUO_W-1:0]               quo_reg;
    logic                           neg_reg;
    logic signed [31:0]             prod_reg;
    logic signed [atpt_pkg::TEMP_W-1:0] temp_reg;
    logic [atpt_pkg::STAT_W-1:0]    status_reg;

    logic [SAMPLE_BITS-1:0]         s_low;
    logic [SUM_W-1:0]               sum_inc;
    logic [atpt_pkg::COUNT_W-1:0]   taken_inc, target;
    logic                           close;
    logic [CODE_W:0]                trial;
    logic                           ge;
    logic [CODE_W-1:0]              rem_next;
    logic signed [CODE_W:0]         num, den, den_mag;
    logic signed [31:0]             prod_next, prod_mag;
    logic signed [31:0]             q_signed, t_val;
    logic signed [atpt_pkg::TEMP_W-1:0] temp_next;
    logic [atpt_pkg::STAT_W-1:0]    status_next;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_low_reg  <= '0;
            cal_high_reg <= '1;
            count_reg    <= atpt_pkg::COUNT_W'(10);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                atpt_pkg::REG_CAL_LOW:      cal_low_reg  <= cfg_data;
                atpt_pkg::REG_CAL_HIGH:     cal_high_reg <= cfg_data;
                atpt_pkg::REG_SAMPLE_COUNT: count_reg    <= cfg_data[atpt_pkg::COUNT_W-1:0];
                default:                    ;
            endcase
        end
    end

    // Batch bookkeeping: a zero count acts as one
    always_comb
    begin
        s_low     = sample[SAMPLE_BITS-1:0];
        sum_inc   = sum_reg + {{(SUM_W-SAMPLE_BITS){1'b0}}, s_low};
        taken_inc = taken_reg + atpt_pkg::COUNT_W'(1);
        target    = (count_reg == '0) ? atpt_pkg::COUNT_W'(1) : count_reg;
        close     = (taken_inc == '0) || (taken_inc >= target);
    end

    assign stat.batch_close = close;

    // Divider iteration: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, quo_reg[QUO_W-1]};
        ge       = trial >= {1'b0, div_reg};
        rem_next = ge ? CODE_W'(trial - {1'b0, div_reg}) : trial[CODE_W-1:0];
    end

    // Calibration arithmetic: signed differences against cal_low
    always_comb
    begin
        num       = $signed({1'b0, quo_reg[CODE_W-1:0]}) - $signed({1'b0, cal_low_reg});
        den       = $signed({1'b0, cal_high_reg}) - $signed({1'b0, cal_low_reg});
        den_mag   = den[CODE_W] ? -den : den;
        prod_next = 32'(num) * 32'(atpt_pkg::SCALE);
        prod_mag  = prod_reg[31] ? -prod_reg : prod_reg;
    end

    // Restore the quotient sign, add the offset and saturate; equal calibration codes give zero and STATUS_CAL_EQ
    always_comb
    begin
        q_signed = neg_reg ? -$signed({3'b000, quo_reg}) : $signed({3'b000, quo_reg});
        t_val    = q_signed + 32'(atpt_pkg::OFFSET);
        if (den == '0)
        begin
            temp_next   = '0;
            status_next = atpt_pkg::STATUS_CAL_EQ;
        end
        else if (t_val > 32'(atpt_pkg::TEMP_MAX))
        begin
            temp_next   = atpt_pkg::TEMP_W'(atpt_pkg::TEMP_MAX);
            status_next = atpt_pkg::STATUS_SAT;
        end
        else if (t_val < 32'(atpt_pkg::TEMP_MIN))
        begin
            temp_next   = atpt_pkg::TEMP_W'(atpt_pkg::TEMP_MIN);
            status_next = atpt_pkg::STATUS_SAT;
        end
        else
        begin
            temp_next   = t_val[atpt_pkg::TEMP_W-1:0];
            status_next = atpt_pkg::STATUS_OK;
        end
    end

    // Accumulator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            taken_reg <= '0;
        end
        else if (cmd.accept)
        begin
            sum_reg   <= close ? '0 : sum_inc;
            taken_reg <= close ? '0 : taken_inc;
        end
    end

    // Divider, multiplier and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept && close)
        begin
            rem_reg <= '0;
            quo_reg <= QUO_W'(sum_inc);
            div_reg <= {{(CODE_W-atpt_pkg::COUNT_W-1){1'b0}}, (taken_inc == '0), taken_inc};
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
        else if (cmd.load_div2)
        begin
            rem_reg <= '0;
            quo_reg <= prod_mag[QUO_W-1:0];
            div_reg <= den_mag[CODE_W-1:0];
            neg_reg <= prod_reg[31] ^ den[CODE_W];
        end
        if (cmd.mul)
            prod_reg <= prod_next;
        if (cmd.finish)
        begin
            temp_reg   <= temp_next;
            status_reg <= status_next;
        end
    end

    assign temperature_centi = temp_reg;
    assign status            = status_reg;

endmodule

// ===== hw/rtl/atpt_ctrl.sv =====
// atpt_ctrl: sequencer for batch accept, two divisions, multiply and result
// handoff; owns the output valid flag. Depends on atpt_pkg.
module atpt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  atpt_pkg::dp_status_t stat,
    output atpt_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1,
        ST_MUL,
        ST_LOAD2,
        ST_DIV2,
        ST_FIN
    } state_t;

    state_t                      state_reg, state_next;
    logic [atpt_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        last_step, out_free;

    assign last_step = (cnt_reg == atpt_pkg::STEP_W'(atpt_pkg::DIV_STEPS - 1));
    assign out_free  = !out_valid_reg || !out_stall;

    // Decode commands and next state
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && stat.batch_close)
                begin
                    state_next = ST_DIV1;
                    cnt_next   = '0;
                end
            end
            ST_DIV1:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + atpt_pkg::STEP_W'(1);
                if (last_step)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_LOAD2;
            end
            ST_LOAD2:
            begin
                cmd.load_div2 = 1'b1;
                cnt_next      = '0;
                state_next    = ST_DIV2;
            end
            ST_DIV2:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + atpt_pkg::STEP_W'(1);
                if (last_step)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold the result until the output register is free
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/averaged_two_point_temperature.sv =====
// averaged_two_point_temperature: top level, averages sensor samples and maps
// the mean through two calibration codes. Depends on atpt_pkg, atpt_ctrl, atpt_dp.
//
//   channel  signals                       payload
//   in       in_valid / in_stall           sample
//   out      out_valid / out_stall         temperature_centi, status
//   cfg      cfg_we, cfg_index, cfg_data   cal_low, cal_high, sample_count
//
// A sample that does not close a batch is added to the running sum. A closing
// sample starts a conversion: the shared restoring divider runs 29 iterations for
// the mean and 29 for the calibration quotient, one bit per cycle.
// Reset sets the calibration codes to 0 and 65535, the count to 10, and empties
// the batch. in_stall is high while a conversion runs; a result waiting on
// out_stall holds the controller in its final step only.
module averaged_two_point_temperature #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [atpt_pkg::CODE_W-1:0]          sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [atpt_pkg::TEMP_W-1:0]   temperature_centi,
    output logic [atpt_pkg::STAT_W-1:0]          status,
    input  logic                                 cfg_we,
    input  logic [atpt_pkg::IDX_W-1:0]           cfg_index,
    input  logic [atpt_pkg::CODE_W-1:0]          cfg_data
);

    atpt_pkg::dp_cmd_t    dp_cmd;
    atpt_pkg::dp_status_t dp_stat;

    // Sequencer
    atpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    // Arithmetic and storage
    atpt_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .sample            (sample),
        .cmd               (dp_cmd),
        .stat              (dp_stat),
        .temperature_centi (temperature_centi),
        .status            (status)
    );

    // Every accepted transaction is taken into the batch
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> dp_cmd.accept)
        else $error("accepted sample not taken into batch");

    // A result is written only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.finish |-> !out_valid || !out_stall)
        else $error("result overwrote a pending transaction");

    // The second division loads only right after the product is registered
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.load_div2 |-> $past(dp_cmd.mul))
        else $error("divider loaded before product was ready");

    // A saturated result sits at one of the rails
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == atpt_pkg::STATUS_SAT |->
            temperature_centi == 16'sh7FFF || temperature_centi == 16'sh8000)
        else $error("saturated status without a rail value");

endmodule
